### hw/rtl/brr_pkg.sv
// shared types and codes of the box to region remapper
package brr_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_MAP   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_LAT,
    S_DST,
    S_DIV,
    S_MAP,
    S_WH,
    S_AREA,
    S_MUL2,
    S_UPD,
    S_FIN
  } state_e;

  // control from the sequencer to the region table
  typedef struct packed {
    logic wr;
    logic clr;
    logic rd;
  } tbl_ctrl_t;

  localparam int unsigned ThrBits   = 17;
  localparam int unsigned ThrReset  = 32768;
  localparam int unsigned FracShift = 16;

endpackage

### hw/rtl/brr_table.sv
// region table: synchronous entry memory plus valid flags
module brr_table #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned EW    = 130
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  brr_pkg::tbl_ctrl_t   ctrl_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [EW-1:0]        wdata_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [EW-1:0]        rdata_o,
  output logic [Depth-1:0]     valid_o
);
  import brr_pkg::*;

  logic [EW-1:0]    mem_q [Depth];
  logic [EW-1:0]    rdata_q;
  logic [Depth-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctrl_i.rd) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctrl_i.clr) begin
      valid_q <= '0;
    end else if (ctrl_i.wr) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  assign rdata_o = rdata_q;
  assign valid_o = valid_q;

endmodule

### hw/rtl/brr_div.sv
// four-lane restoring divider, one quotient bit per lane per cycle
module brr_div #(
  parameter int unsigned C = 13
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [2*C-1:0] dividend_i [4],
  input  logic [C-1:0]   divisor_i,
  output logic [2*C-1:0] quotient_o [4],
  output logic           busy_o
);
  import brr_pkg::*;

  localparam int unsigned QW = 2 * C;
  localparam int unsigned CNTW = $clog2(QW + 1);

  logic [QW-1:0]   quo_q [4];
  logic [QW-1:0]   quo_d [4];
  logic [C-1:0]    rem_q [4];
  logic [C-1:0]    rem_d [4];
  logic [C:0]      trial [4];
  logic [C:0]      sub   [4];
  logic            run_q;
  logic [CNTW-1:0] cnt_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      trial[k] = {rem_q[k], quo_q[k][QW-1]};
      sub[k]   = trial[k] - {1'b0, divisor_i};
      if (trial[k] >= {1'b0, divisor_i}) begin
        rem_d[k] = sub[k][C-1:0];
        quo_d[k] = {quo_q[k][QW-2:0], 1'b1};
      end else begin
        rem_d[k] = trial[k][C-1:0];
        quo_d[k] = {quo_q[k][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      if (start_i) begin
        quo_q[k] <= dividend_i[k];
        rem_q[k] <= '0;
      end else if (run_q) begin
        quo_q[k] <= quo_d[k];
        rem_q[k] <= rem_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNTW'(QW - 1)) begin
        run_q <= 1'b0;
      end
    end
  end

  assign quotient_o = quo_q;
  assign busy_o     = run_q;

endmodule

### hw/rtl/box_to_region_remap_assign_core.sv
// top level of the box to region remapper: sequencer, datapath and ports
//
// usage
//   one command channel: a word is taken at a clock edge with start high and
//   busy low. op load writes one region entry, op clear drops every entry,
//   op map maps a detection box through all valid entries.
//   load and clear finish in the accepting cycle and give no result word.
//   a map gives exactly one result word, shown on the result ports for one
//   cycle with result_valid_o high; the receiver cannot stall it.
// scan
//   a map scans the table one entry at a time. an invalid entry is skipped in
//   the read state; a valid one waits on the bit-serial divider (one quotient
//   bit per cycle, all box edges in parallel). the end of the scan is seen in the
//   read state and is followed by the threshold check; the result word shows
//   in the first idle cycle after.
//   busy stays high for the whole scan; one item is worked at a time.
// configuration
//   cfg_we_i writes the overlap threshold at once; write only while idle.
// reset
//   rst_ni clears valid flags, sequencer and threshold (32768); entry
//   contents are not cleared. no clearing pass is needed.
module box_to_region_remap_assign_core #(
  parameter int unsigned MAX_REGIONS = 16,
  parameter int unsigned COORD_BITS  = 13
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 op_i,
  input  logic [3:0]                 entry_index_i,
  input  logic [COORD_BITS-1:0]      offset_x_i,
  input  logic [COORD_BITS-1:0]      offset_y_i,
  input  logic [COORD_BITS-1:0]      scale_num_i,
  input  logic [COORD_BITS-1:0]      scale_den_i,
  input  logic [COORD_BITS-1:0]      left_i,
  input  logic [COORD_BITS-1:0]      top_i,
  input  logic [COORD_BITS-1:0]      right_i,
  input  logic [COORD_BITS-1:0]      bottom_i,
  input  logic [COORD_BITS-1:0]      frame_width_i,
  input  logic [COORD_BITS-1:0]      frame_height_i,
  input  logic                       cfg_we_i,
  input  logic [brr_pkg::ThrBits-1:0] cfg_wdata_i,
  output logic                       result_valid_o,
  output logic                       accepted_o,
  output logic [3:0]                 best_entry_o,
  output logic                       any_region_o,
  output logic [COORD_BITS-1:0]      mapped_left_o,
  output logic [COORD_BITS-1:0]      mapped_top_o,
  output logic signed [COORD_BITS+1:0] mapped_right_o,
  output logic signed [COORD_BITS+1:0] mapped_bottom_o
);
  import brr_pkg::*;

  localparam int unsigned C    = COORD_BITS;
  localparam int unsigned QW   = 2 * C;       // product and quotient magnitude
  localparam int unsigned MW   = 2 * C + 2;   // mapped edge, signed
  localparam int unsigned WW   = 2 * C + 3;   // edge differences, signed
  localparam int unsigned PW   = 2 * QW;      // cross products
  localparam int unsigned TW   = QW + ThrBits;
  localparam int unsigned EW   = 10 * C;
  localparam int unsigned AW   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CW   = $clog2(MAX_REGIONS + 1);

  state_e state_q, state_d;

  // handshake
  logic acc_cmd;
  assign acc_cmd = start && !busy;

  // threshold register
  logic [ThrBits-1:0] thr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrBits'(ThrReset);
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // region table
  tbl_ctrl_t          tctrl;
  logic [31:0]        ei_wide;
  logic [AW-1:0]      waddr;
  logic [EW-1:0]      wdata;
  logic [EW-1:0]      rdata;
  logic [MAX_REGIONS-1:0] valid;
  logic [CW-1:0]      idx_q;
  logic [C-1:0]       den_fix;
  logic               at_end;

  assign ei_wide = 32'(entry_index_i);
  assign waddr   = ei_wide[AW-1:0];
  assign den_fix = (scale_den_i == '0) ? C'(1) : scale_den_i;
  assign wdata   = {frame_height_i, frame_width_i, bottom_i, right_i, top_i, left_i,
                    den_fix, scale_num_i, offset_y_i, offset_x_i};
  assign at_end  = (idx_q == CW'(MAX_REGIONS));

  brr_table #(.Depth(MAX_REGIONS), .AW(AW), .EW(EW)) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (tctrl),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata),
    .valid_o (valid)
  );

  // entry fields, held in the table's read register through the whole entry
  logic [C-1:0] e_offx, e_offy, e_num, e_den, e_wl, e_wt, e_wr, e_wb, e_fw, e_fh;
  assign e_offx = rdata[0*C +: C];
  assign e_offy = rdata[1*C +: C];
  assign e_num  = rdata[2*C +: C];
  assign e_den  = rdata[3*C +: C];
  assign e_wl   = rdata[4*C +: C];
  assign e_wt   = rdata[5*C +: C];
  assign e_wr   = rdata[6*C +: C];
  assign e_wb   = rdata[7*C +: C];
  assign e_fw   = rdata[8*C +: C];
  assign e_fh   = rdata[9*C +: C];

  // divider
  logic          div_start, div_busy;
  logic [QW-1:0] prod_q [4];
  logic [QW-1:0] quo    [4];

  brr_div #(.C(C)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (e_den),
    .quotient_o (quo),
    .busy_o     (div_busy)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (acc_cmd && op_i == OP_MAP) state_d = S_RD;
      S_RD: begin
        if (at_end) begin
          state_d = S_FIN;
        end else if (valid[idx_q[AW-1:0]]) begin
          state_d = S_LAT;
        end
      end
      S_LAT:  state_d = S_DST;
      S_DST:  state_d = S_DIV;
      S_DIV:  if (!div_busy) state_d = S_MAP;
      S_MAP:  state_d = S_WH;
      S_WH:   state_d = S_AREA;
      S_AREA: state_d = S_MUL2;
      S_MUL2: state_d = S_UPD;
      S_UPD:  state_d = S_RD;
      S_FIN:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    tctrl.wr  = acc_cmd && (op_i == OP_LOAD) && (ei_wide < 32'(MAX_REGIONS));
    tctrl.clr = acc_cmd && (op_i == OP_CLEAR);
    tctrl.rd  = (state_q == S_RD) && !at_end;
    div_start = (state_q == S_DST);
    busy      = (state_q != S_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // stage logic: lanes 0..3 are left, top, right, bottom
  logic [C-1:0]        box_q [4];
  logic                neg_q [4];
  logic signed [C:0]   diff  [4];
  logic signed [C:0]   mag_s [4];
  logic [QW-1:0]       prod_d [4];
  logic signed [MW-1:0] qs   [4];
  logic signed [MW-1:0] m    [4];
  logic signed [MW-1:0] l_d, t_d, r_d, b_d;
  logic signed [MW-1:0] l_q, t_q, r_q, b_q;
  logic signed [MW-1:0] fw_s, fh_s, wl_s, wt_s, wr_s, wb_s;
  logic signed [WW-1:0] w_s, h_s, iw_s, ih_s;
  logic signed [MW-1:0] ir_min, il_max, ib_min, it_max;

  assign fw_s = MW'($signed({1'b0, e_fw}));
  assign fh_s = MW'($signed({1'b0, e_fh}));
  assign wl_s = MW'($signed({1'b0, e_wl}));
  assign wt_s = MW'($signed({1'b0, e_wt}));
  assign wr_s = MW'($signed({1'b0, e_wr}));
  assign wb_s = MW'($signed({1'b0, e_wb}));

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      diff[k]   = $signed({1'b0, box_q[k]}) -
                  $signed({1'b0, ((k % 2) == 0) ? e_offx : e_offy});
      mag_s[k]  = diff[k][C] ? -diff[k] : diff[k];
      prod_d[k] = QW'(mag_s[k][C-1:0]) * QW'(e_num);
      qs[k]     = neg_q[k] ? -$signed(MW'(quo[k])) : $signed(MW'(quo[k]));
      m[k]      = qs[k] + (((k % 2) == 0) ? wl_s : wt_s);
    end
    l_d = (m[0] < 0) ? '0 : m[0];
    t_d = (m[1] < 0) ? '0 : m[1];
    r_d = (m[2] > fw_s) ? fw_s : m[2];
    b_d = (m[3] > fh_s) ? fh_s : m[3];
    ir_min = (r_q < wr_s) ? r_q : wr_s;
    il_max = (l_q > wl_s) ? l_q : wl_s;
    ib_min = (b_q < wb_s) ? b_q : wb_s;
    it_max = (t_q > wt_s) ? t_q : wt_s;
    w_s  = WW'(r_q) - WW'(l_q);
    h_s  = WW'(b_q) - WW'(t_q);
    iw_s = WW'(ir_min) - WW'(il_max);
    ih_s = WW'(ib_min) - WW'(it_max);
  end

  logic [C-1:0]   w_q, h_q, iw_q, ih_q;
  logic           ok_q;
  logic [QW-1:0]  area_q, inter_q;
  logic [PW-1:0]  p_new_q, p_best_q;
  logic           found_q;
  logic [AW-1:0]  best_q;
  logic [QW-1:0]  best_inter_q, best_area_q;
  logic signed [MW-1:0] bl_q, bt_q, br_q, bb_q;
  logic [TW-1:0]  thr_lhs, thr_rhs;
  logic [31:0]    best_wide;

  assign thr_lhs   = TW'(best_inter_q) << FracShift;
  assign thr_rhs   = TW'(thr_q) * TW'(best_area_q);
  assign best_wide = 32'(best_q);

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        box_q[0] <= left_i;
        box_q[1] <= top_i;
        box_q[2] <= right_i;
        box_q[3] <= bottom_i;
        best_q       <= '0;
        best_inter_q <= '0;
        best_area_q  <= QW'(1);
        bl_q <= '0;
        bt_q <= '0;
        br_q <= '0;
        bb_q <= '0;
      end
      S_LAT: begin
        for (int k = 0; k < 4; k++) begin
          prod_q[k] <= prod_d[k];
          neg_q[k]  <= diff[k][C];
        end
      end
      S_MAP: begin
        l_q <= l_d;
        t_q <= t_d;
        r_q <= r_d;
        b_q <= b_d;
      end
      S_WH: begin
        // positive widths never exceed the frame size, so the low bits suffice
        ok_q <= (w_s > 0) && (h_s > 0);
        w_q  <= w_s[C-1:0];
        h_q  <= h_s[C-1:0];
        iw_q <= (iw_s > 0) ? iw_s[C-1:0] : '0;
        ih_q <= (ih_s > 0) ? ih_s[C-1:0] : '0;
      end
      S_AREA: begin
        area_q  <= QW'(w_q) * QW'(h_q);
        inter_q <= QW'(iw_q) * QW'(ih_q);
      end
      S_MUL2: begin
        p_new_q  <= PW'(inter_q) * PW'(best_area_q);
        p_best_q <= PW'(best_inter_q) * PW'(area_q);
      end
      S_UPD: begin
        // first strict maximum in index order wins
        if (ok_q && (!found_q || p_new_q > p_best_q)) begin
          best_q       <= idx_q[AW-1:0];
          best_inter_q <= inter_q;
          best_area_q  <= area_q;
          bl_q <= l_q;
          bt_q <= t_q;
          br_q <= r_q;
          bb_q <= b_q;
        end
      end
      S_FIN: begin
        accepted_o      <= found_q && (thr_lhs >= thr_rhs);
        best_entry_o    <= best_wide[3:0];
        any_region_o    <= found_q;
        mapped_left_o   <= bl_q[C-1:0];
        mapped_top_o    <= bt_q[C-1:0];
        mapped_right_o  <= br_q[C+1:0];
        mapped_bottom_o <= bb_q[C+1:0];
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q          <= '0;
      found_q        <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= (state_q == S_FIN);
      case (state_q)
        S_IDLE: begin
          idx_q   <= '0;
          found_q <= 1'b0;
        end
        S_RD: begin
          if (!at_end && !valid[idx_q[AW-1:0]]) begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_UPD: begin
          if (ok_q && (!found_q || p_new_q > p_best_q)) begin
            found_q <= 1'b1;
          end
          idx_q <= idx_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // checks
  a_strobe_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == S_FIN))
    else $error("result strobe without finished scan");
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");
  a_accept_needs_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && accepted_o) |-> any_region_o)
    else $error("accepted without any region");
  a_map_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_i == OP_MAP) |=> (state_q == S_RD && idx_q == '0))
    else $error("map word did not start a scan");
  a_no_read_during_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == S_DIV))
    else $error("divider running outside its wait state");

endmodule
